// ----- sv/msiu_pkg.sv -----
// Shared opcodes, command and status types for the special integer unit.
`default_nettype none
package msiu_pkg;
   localparam int unsigned XLEN = 64;
   localparam int unsigned CNT_W = 7;

   localparam logic [5:0] OP_SLL    = 6'd0;
   localparam logic [5:0] OP_SRL    = 6'd2;
   localparam logic [5:0] OP_SRA    = 6'd3;
   localparam logic [5:0] OP_SLLV   = 6'd4;
   localparam logic [5:0] OP_SRLV   = 6'd6;
   localparam logic [5:0] OP_SRAV   = 6'd7;
   localparam logic [5:0] OP_MFHI   = 6'd16;
   localparam logic [5:0] OP_MTHI   = 6'd17;
   localparam logic [5:0] OP_MFLO   = 6'd18;
   localparam logic [5:0] OP_MTLO   = 6'd19;
   localparam logic [5:0] OP_DSLLV  = 6'd20;
   localparam logic [5:0] OP_DSRLV  = 6'd22;
   localparam logic [5:0] OP_DSRAV  = 6'd23;
   localparam logic [5:0] OP_MULT   = 6'd24;
   localparam logic [5:0] OP_MULTU  = 6'd25;
   localparam logic [5:0] OP_DIV    = 6'd26;
   localparam logic [5:0] OP_DIVU   = 6'd27;
   localparam logic [5:0] OP_DMULT  = 6'd28;
   localparam logic [5:0] OP_DMULTU = 6'd29;
   localparam logic [5:0] OP_DDIV   = 6'd30;
   localparam logic [5:0] OP_DDIVU  = 6'd31;
   localparam logic [5:0] OP_ADD    = 6'd32;
   localparam logic [5:0] OP_ADDU   = 6'd33;
   localparam logic [5:0] OP_SUB    = 6'd34;
   localparam logic [5:0] OP_SUBU   = 6'd35;
   localparam logic [5:0] OP_AND    = 6'd36;
   localparam logic [5:0] OP_OR     = 6'd37;
   localparam logic [5:0] OP_XOR    = 6'd38;
   localparam logic [5:0] OP_NOR    = 6'd39;
   localparam logic [5:0] OP_SLT    = 6'd42;
   localparam logic [5:0] OP_SLTU   = 6'd43;
   localparam logic [5:0] OP_DADD   = 6'd44;
   localparam logic [5:0] OP_DADDU  = 6'd45;
   localparam logic [5:0] OP_DSUB   = 6'd46;
   localparam logic [5:0] OP_DSUBU  = 6'd47;
   localparam logic [5:0] OP_DSLL   = 6'd56;
   localparam logic [5:0] OP_DSRL   = 6'd58;
   localparam logic [5:0] OP_DSRA   = 6'd59;
   localparam logic [5:0] OP_DSLL32 = 6'd60;
   localparam logic [5:0] OP_DSRL32 = 6'd62;
   localparam logic [5:0] OP_DSRA32 = 6'd63;

   typedef enum logic [1:0] {
      KIND_ALU  = 2'd0,
      KIND_MUL  = 2'd1,
      KIND_DIV  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // capture operands
      logic start;  // set up iterative unit
      logic step;   // one multiply/divide iteration
      logic commit; // write HI/LO, form result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      kind_type kind;
      logic     last;  // all iterations done
   } sts_type;

   function automatic logic [63:0] sext32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction
endpackage
`default_nettype wire

// ----- sv/msiu_ctrl.sv -----
// Sequencer for the special integer unit: handshake and multi-cycle control.
`default_nettype none
module msiu_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire msiu_pkg::sts_type sts,
   output msiu_pkg::cmd_type    cmd
);
   import msiu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DEC  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;
   logic       slot_free;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   // result register is free or is being drained this cycle
   assign slot_free  = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd      = '0;
      cmd.load = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DEC;
         end
         ST_DEC: begin
            if (sts.kind == KIND_MUL || sts.kind == KIND_DIV) begin
               cmd.start = 1'b1;
               state_in  = ST_RUN;
            end else if (slot_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (sts.last) begin
               // hold the finished word until the result register frees up
               if (slot_free) begin
                  cmd.commit = 1'b1;
                  valid_in   = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTH
   a_commit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid) else $error("result not presented after commit");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("accept while busy");
   a_hold_unsent: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ----- sv/msiu_dpath.sv -----
// Datapath: ALU and shifter, radix-2 multiplier and divider, HI/LO registers.
`default_nettype none
module msiu_dpath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire msiu_pkg::cmd_type cmd,
   input  wire logic [5:0]       in_type,
   input  wire logic [63:0]      in_rs,
   input  wire logic [63:0]      in_rt,
   input  wire logic [4:0]       in_sa,
   output msiu_pkg::sts_type     sts,
   output logic [63:0]           rd_value,
   output logic                  rd_write
);
   import msiu_pkg::*;

   logic [5:0]  op_ff;
   logic [63:0] rs_ff, rt_ff;
   logic [4:0]  sa_ff;
   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [63:0] rdv_ff, rdv_in;
   logic        rdw_ff, rdw_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   // mul: acc holds running upper product, mq holds multiplier/low bits
   // div: acc holds remainder, mq holds dividend/quotient
   logic [64:0] acc_ff, acc_in;
   logic [63:0] mq_ff, mq_in;
   logic [63:0] dvs_ff, dvs_in;
   logic        nq_ff, nq_in, nr_ff, nr_in, zero_ff, zero_in;

   kind_type kind;
   logic     is_word, is_signed;
   logic [63:0] alu_rd;
   logic        alu_wr;
   logic [63:0] a_op, b_op;
   logic [6:0]  total;
   logic [64:0] sum;
   logic [64:0] trial;
   logic [63:0] q_fix, r_fix, hi_mul, lo_mul;
   logic [63:0] p_word;
   logic [63:0] rt32s;
   logic [5:0]  amt;
   logic [63:0] sh_l, sh_r, sh_a;

   always_comb begin
      unique case (op_ff)
         OP_MULT, OP_MULTU, OP_DMULT, OP_DMULTU: kind = KIND_MUL;
         OP_DIV, OP_DIVU, OP_DDIV, OP_DDIVU:     kind = KIND_DIV;
         OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV, OP_MFHI, OP_MTHI,
         OP_MFLO, OP_MTLO, OP_DSLLV, OP_DSRLV, OP_DSRAV, OP_ADD, OP_ADDU,
         OP_SUB, OP_SUBU, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
         OP_DADD, OP_DADDU, OP_DSUB, OP_DSUBU, OP_DSLL, OP_DSRL, OP_DSRA,
         OP_DSLL32, OP_DSRL32, OP_DSRA32: kind = KIND_ALU;
         default: kind = KIND_NONE;
      endcase
   end
   assign is_word   = !op_ff[2];
   assign is_signed = !op_ff[0];
   assign total     = is_word ? 7'd32 : 7'd64;
   assign sts.kind  = kind;
   assign sts.last  = (cnt_ff == total);

   // left, logical right and arithmetic right shifters shared by all shift codes
   assign rt32s = sext32(rt_ff[31:0]);
   always_comb begin
      unique case (op_ff)
         OP_SLLV, OP_SRLV, OP_SRAV:    amt = {1'b0, rs_ff[4:0]};
         OP_DSLLV, OP_DSRLV, OP_DSRAV: amt = rs_ff[5:0];
         OP_DSLL32, OP_DSRL32, OP_DSRA32: amt = {1'b1, sa_ff};
         default:                      amt = {1'b0, sa_ff};
      endcase
   end
   assign sh_l = (op_ff[4] || op_ff[5]) ? (rt_ff << amt) : (rt32s << amt);
   assign sh_r = (op_ff[4] || op_ff[5]) ? (rt_ff >> amt) : ({32'd0, rt_ff[31:0]} >> amt);
   assign sh_a = (op_ff[4] || op_ff[5]) ? 64'($signed(rt_ff) >>> amt)
                                        : 64'($signed(rt32s) >>> amt);

   always_comb begin
      alu_rd = '0;
      alu_wr = 1'b1;
      unique case (op_ff)
         OP_SLL, OP_SLLV:   alu_rd = sext32(sh_l[31:0]);
         OP_SRL, OP_SRLV:   alu_rd = sext32(sh_r[31:0]);
         OP_SRA, OP_SRAV:   alu_rd = sh_a;
         OP_DSLLV, OP_DSLL, OP_DSLL32: alu_rd = sh_l;
         OP_DSRLV, OP_DSRL, OP_DSRL32: alu_rd = sh_r;
         OP_DSRAV, OP_DSRA, OP_DSRA32: alu_rd = sh_a;
         OP_MFHI:           alu_rd = hi_ff;
         OP_MFLO:           alu_rd = lo_ff;
         OP_ADD, OP_ADDU:   alu_rd = sext32(rs_ff[31:0] + rt_ff[31:0]);
         OP_SUB, OP_SUBU:   alu_rd = sext32(rs_ff[31:0] - rt_ff[31:0]);
         OP_AND:            alu_rd = rs_ff & rt_ff;
         OP_OR:             alu_rd = rs_ff | rt_ff;
         OP_XOR:            alu_rd = rs_ff ^ rt_ff;
         OP_NOR:            alu_rd = ~(rs_ff | rt_ff);
         OP_SLT:            alu_rd = {63'd0, $signed(rs_ff) < $signed(rt_ff)};
         OP_SLTU:           alu_rd = {63'd0, rs_ff < rt_ff};
         OP_DADD, OP_DADDU: alu_rd = rs_ff + rt_ff;
         OP_DSUB, OP_DSUBU: alu_rd = rs_ff - rt_ff;
         default:           alu_wr = 1'b0;
      endcase
   end

   // operands zero-extended (word) or raw (doubleword) for the iterative unit
   always_comb begin
      if (is_word) begin
         a_op = {32'd0, rs_ff[31:0]};
         b_op = {32'd0, rt_ff[31:0]};
      end else begin
         a_op = rs_ff;
         b_op = rt_ff;
      end
   end

   assign sum   = acc_ff + (mq_ff[0] ? {1'b0, dvs_ff} : 65'd0);
   assign trial = {acc_ff[63:0], mq_ff[63]} - {1'b0, dvs_ff};

   always_comb begin
      acc_in  = acc_ff;
      mq_in   = mq_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      nr_in   = nr_ff;
      zero_in = zero_ff;
      if (cmd.start) begin
         cnt_in = '0;
         acc_in = '0;
         if (kind == KIND_MUL) begin
            // unsigned product, signed fixed at commit
            mq_in  = a_op;
            dvs_in = b_op;
         end else begin
            nq_in   = is_signed && (is_word ? (rs_ff[31] ^ rt_ff[31]) : (rs_ff[63] ^ rt_ff[63]));
            nr_in   = is_signed && (is_word ? rs_ff[31] : rs_ff[63]);
            zero_in = (b_op == 64'd0);
            if (is_word) begin
               mq_in  = {(is_signed && rs_ff[31]) ? 32'(-rs_ff[31:0]) : rs_ff[31:0], 32'd0};
               dvs_in = {32'd0, (is_signed && rt_ff[31]) ? 32'(-rt_ff[31:0]) : rt_ff[31:0]};
            end else begin
               mq_in  = (is_signed && rs_ff[63]) ? -rs_ff : rs_ff;
               dvs_in = (is_signed && rt_ff[63]) ? -rt_ff : rt_ff;
            end
         end
      end else if (cmd.step) begin
         cnt_in = cnt_ff + 1'b1;
         if (kind == KIND_MUL) begin
            // shift right: next product bit falls into the top of mq (bit 31 for words)
            if (is_word) begin
               acc_in = {33'd0, sum[32:1]};
               mq_in  = {32'd0, sum[0], mq_ff[31:1]};
            end else begin
               acc_in = {1'b0, sum[64:1]};
               mq_in  = {sum[0], mq_ff[63:1]};
            end
         end else if (!trial[64]) begin
            acc_in = trial;
            mq_in  = {mq_ff[62:0], 1'b1};
         end else begin
            acc_in = {acc_ff[63:0], mq_ff[63]};
            mq_in  = {mq_ff[62:0], 1'b0};
         end
      end
   end

   assign q_fix  = nq_ff ? -mq_ff : mq_ff;
   assign r_fix  = nr_ff ? -acc_ff[63:0] : acc_ff[63:0];
   // 32-bit product: upper half in acc, lower half in mq
   assign p_word = {acc_ff[31:0], mq_ff[31:0]};
   // signed correction of the unsigned product
   always_comb begin
      hi_mul = acc_ff[63:0];
      lo_mul = mq_ff;
      if (is_word) begin
         hi_mul = sext32(p_word[63:32] - ((is_signed && rs_ff[31]) ? rt_ff[31:0] : 32'd0)
                         - ((is_signed && rt_ff[31]) ? rs_ff[31:0] : 32'd0));
         lo_mul = sext32(p_word[31:0]);
      end else if (is_signed) begin
         hi_mul = acc_ff[63:0] - (rs_ff[63] ? rt_ff : 64'd0) - (rt_ff[63] ? rs_ff : 64'd0);
      end
   end

   always_comb begin
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      rdv_in = rdv_ff;
      rdw_in = rdw_ff;
      if (cmd.commit) begin
         rdv_in = alu_wr ? alu_rd : 64'd0;
         rdw_in = alu_wr;
         unique case (kind)
            KIND_ALU: begin
               if (op_ff == OP_MTHI) hi_in = rs_ff;
               if (op_ff == OP_MTLO) lo_in = rs_ff;
            end
            KIND_MUL: begin
               hi_in = hi_mul;
               lo_in = lo_mul;
            end
            KIND_DIV: begin
               if (!zero_ff) begin
                  if (is_word) begin
                     hi_in = sext32(r_fix[31:0]);
                     lo_in = sext32(q_fix[31:0]);
                  end else begin
                     hi_in = r_fix;
                     lo_in = q_fix;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_ff <= '0;
         lo_ff <= '0;
      end else begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_type;
         rs_ff <= in_rs;
         rt_ff <= in_rt;
         sa_ff <= in_sa;
      end
      acc_ff  <= acc_in;
      mq_ff   <= mq_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      nq_ff   <= nq_in;
      nr_ff   <= nr_in;
      zero_ff <= zero_in;
      rdv_ff  <= rdv_in;
      rdw_ff  <= rdw_in;
   end

   assign rd_value = rdv_ff;
   assign rd_write = rdw_ff;

`ifndef SYNTH
   a_hilo_only_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.commit) |-> ($stable(hi_ff) && $stable(lo_ff)))
      else $error("HI/LO changed outside commit");
   a_write_value: assert property (@(posedge clock) disable iff (reset)
      !rdw_ff |-> rdv_ff == 64'd0) else $error("nonzero value without write");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> cnt_ff < total) else $error("iteration overrun");
`endif
endmodule
`default_nettype wire

// ----- sv/mips64_special_integer_unit.sv -----
// Special integer unit with HI/LO. ALU, shift and HI/LO move codes go
// through the decode state and commit, raising rsp_tvalid once the result
// register is free; multiply and divide go through decode, one iteration
// per bit of the shift-add multiplier or restoring divider, then commit.
// One word is in flight at a time: the next word is taken the cycle after
// a commit. While a result waits, one new word is still taken and held
// before commit.
`default_nettype none
module mips64_special_integer_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [135:0] req_tdata,  // rs_value[63:0], rt_value[127:64], shift_amount[132:128]
   input  wire logic [5:0]   req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [63:0]       rsp_tdata,  // rd_value
   output logic              rsp_tuser   // rd_write
);
   import msiu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   msiu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   msiu_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .in_type  (req_tuser),
      .in_rs    (req_tdata[63:0]),
      .in_rt    (req_tdata[127:64]),
      .in_sa    (req_tdata[132:128]),
      .sts      (sts),
      .rd_value (rsp_tdata),
      .rd_write (rsp_tuser)
   );
endmodule
`default_nettype wire

// ----- dv/tb_mips64_special_integer_unit.sv -----
// Self-checking testbench for the MIPS64 special integer unit with HI/LO.
`timescale 1ns / 1ps
`default_nettype none
module tb_mips64_special_integer_unit;
   import msiu_pkg::*;

   localparam logic [5:0] OP_SYSCALL_FREE = 6'd12;

   class hilo_scoreboard;
      logic [63:0] hi, lo;
      logic [63:0] rd_q[$];
      logic        wr_q[$];
      int          errors;

      function new();
         hi = '0;
         lo = '0;
         errors = 0;
      endfunction

      // Compute the rd result of one word and update HI/LO.
      function void note_word(logic [5:0] op, logic [63:0] rs, logic [63:0] rt, logic [4:0] sa);
         logic [63:0]  rd;
         logic         wr;
         logic [31:0]  rs32, rt32;
         logic [5:0]   v64;
         logic [127:0] prod;
         logic [63:0]  p32;
         wr = 1'b1;
         rd = '0;
         rs32 = rs[31:0];
         rt32 = rt[31:0];
         v64 = rs[5:0];
         case (op)
            OP_SLL:    rd = sext32(rt32 << sa);
            OP_SRL:    rd = sext32(rt32 >> sa);
            OP_SRA:    rd = $signed(sext32(rt32)) >>> sa;
            OP_SLLV:   rd = sext32(rt32 << rs[4:0]);
            OP_SRLV:   rd = sext32(rt32 >> rs[4:0]);
            OP_SRAV:   rd = $signed(sext32(rt32)) >>> rs[4:0];
            OP_MFHI:   rd = hi;
            OP_MTHI:   begin hi = rs; wr = 1'b0; end
            OP_MFLO:   rd = lo;
            OP_MTLO:   begin lo = rs; wr = 1'b0; end
            OP_DSLLV:  rd = rt << v64;
            OP_DSRLV:  rd = rt >> v64;
            OP_DSRAV:  rd = $signed(rt) >>> v64;
            OP_MULT, OP_MULTU: begin
               if (op == OP_MULT) p32 = $signed(sext32(rs32)) * $signed(sext32(rt32));
               else p32 = {32'd0, rs32} * {32'd0, rt32};
               hi = sext32(p32[63:32]);
               lo = sext32(p32[31:0]);
               wr = 1'b0;
            end
            OP_DIV: begin
               if (rt32 != 0) begin
                  if (rs32 == 32'h8000_0000 && rt32 == 32'hFFFF_FFFF) begin
                     lo = sext32(rs32);
                     hi = '0;
                  end else begin
                     lo = sext32($signed(rs32) / $signed(rt32));
                     hi = sext32($signed(rs32) % $signed(rt32));
                  end
               end
               wr = 1'b0;
            end
            OP_DIVU: begin
               if (rt32 != 0) begin
                  lo = sext32(rs32 / rt32);
                  hi = sext32(rs32 % rt32);
               end
               wr = 1'b0;
            end
            OP_DMULT, OP_DMULTU: begin
               if (op == OP_DMULT) prod = $signed({{64{rs[63]}}, rs}) * $signed({{64{rt[63]}}, rt});
               else prod = {64'd0, rs} * {64'd0, rt};
               hi = prod[127:64];
               lo = prod[63:0];
               wr = 1'b0;
            end
            OP_DDIV: begin
               if (rt != 0) begin
                  if (rs == 64'h8000_0000_0000_0000 && rt == '1) begin
                     lo = rs;
                     hi = '0;
                  end else begin
                     lo = $signed(rs) / $signed(rt);
                     hi = $signed(rs) % $signed(rt);
                  end
               end
               wr = 1'b0;
            end
            OP_DDIVU: begin
               if (rt != 0) begin
                  lo = rs / rt;
                  hi = rs % rt;
               end
               wr = 1'b0;
            end
            OP_ADD, OP_ADDU:  rd = sext32(rs32 + rt32);
            OP_SUB, OP_SUBU:  rd = sext32(rs32 - rt32);
            OP_AND:    rd = rs & rt;
            OP_OR:     rd = rs | rt;
            OP_XOR:    rd = rs ^ rt;
            OP_NOR:    rd = ~(rs | rt);
            OP_SLT:    rd = {63'd0, $signed(rs) < $signed(rt)};
            OP_SLTU:   rd = {63'd0, rs < rt};
            OP_DADD, OP_DADDU: rd = rs + rt;
            OP_DSUB, OP_DSUBU: rd = rs - rt;
            OP_DSLL:   rd = rt << sa;
            OP_DSRL:   rd = rt >> sa;
            OP_DSRA:   rd = $signed(rt) >>> sa;
            OP_DSLL32: rd = rt << (7'd32 + sa);
            OP_DSRL32: rd = rt >> (7'd32 + sa);
            OP_DSRA32: rd = $signed(rt) >>> (7'd32 + sa);
            default:   wr = 1'b0;
         endcase
         rd_q.push_back(wr ? rd : 64'd0);
         wr_q.push_back(wr);
      endfunction

      task check_result(logic [63:0] rd, logic wr);
         logic [63:0] exp_rd;
         logic        exp_wr;
         if (rd_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result rd=%h wr=%b", rd, wr));
            return;
         end
         exp_rd = rd_q.pop_front();
         exp_wr = wr_q.pop_front();
         if (rd !== exp_rd) report_mismatch($sformatf("rd_value %h, want %h", rd, exp_rd));
         if (wr !== exp_wr) report_mismatch($sformatf("rd_write %b, want %b", wr, exp_wr));
      endtask

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
      endtask
   endclass

   localparam int LIMIT = 2_000_000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic [5:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;

   hilo_scoreboard sb = new();
   bit   calm = 1'b0;
   bit   hold_rsp = 1'b0;
   int   cycles = 0;

   logic [5:0] valid_ops[41] = '{OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV,
      OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_DSLLV, OP_DSRLV, OP_DSRAV, OP_MULT,
      OP_MULTU, OP_DIV, OP_DIVU, OP_DMULT, OP_DMULTU, OP_DDIV, OP_DDIVU, OP_ADD,
      OP_ADDU, OP_SUB, OP_SUBU, OP_AND, OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU,
      OP_DADD, OP_DADDU, OP_DSUB, OP_DSUBU, OP_DSLL, OP_DSRL, OP_DSRA, OP_DSLL32,
      OP_DSRL32, OP_DSRA32};

   mips64_special_integer_unit dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("mips64_special_integer_unit verification failed");
         $finish;
      end
   end

   // Check every accepted result word.
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);

   // Receiver: random stall bursts, held off while hold_rsp, none once calm.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(negedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            n = $urandom_range(9, 1);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_word(logic [5:0] op, logic [63:0] rs, logic [63:0] rt, logic [4:0] sa);
      int n;
      if (!calm && $urandom_range(4) == 0) begin
         n = $urandom_range(9, 1);
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'd0, sa, rt, rs};
      // advance until the word is taken
      do @(posedge clock); while (!req_tready);
      sb.note_word(op, rs, rt, sa);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(7))
         0: return 64'd0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'h7FFF_FFFF_FFFF_FFFF;
         4: return {{32{$urandom_range(1) == 1}}, $urandom()};
         5: return {32'd0, 32'h8000_0000 | $urandom_range(1)};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   initial begin
      int i;
      logic [5:0] op;
      logic [63:0] rs, rt;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes and corner cases.
      send_word(OP_MFHI, '0, '0, 5'd0);
      send_word(OP_SLL, '1, '1, 5'd31);
      send_word(OP_SRA, '0, 64'h8000_0000, 5'd31);
      send_word(OP_DSRA32, '0, 64'h8000_0000_0000_0000, 5'd31);
      send_word(OP_DSLLV, 64'h3F, '1, 5'd0);
      send_word(OP_ADD, 64'h7FFF_FFFF, 64'd1, 5'd0);
      send_word(OP_DSUB, 64'h8000_0000_0000_0000, 64'd1, 5'd0);
      send_word(OP_MTHI, 64'h1234_5678_9ABC_DEF0, '0, 5'd0);
      send_word(OP_MTLO, 64'hFEDC_BA98_7654_3210, '0, 5'd0);
      send_word(OP_DIV, 64'd5, 64'd0, 5'd0);
      send_word(OP_MFHI, '0, '0, 5'd0);
      send_word(OP_DDIVU, '1, 64'd0, 5'd0);
      send_word(OP_MFLO, '0, '0, 5'd0);
      send_word(OP_DIV, 64'h8000_0000, 64'hFFFF_FFFF, 5'd0);
      send_word(OP_MFLO, '0, '0, 5'd0);
      send_word(OP_DDIV, 64'h8000_0000_0000_0000, '1, 5'd0);
      send_word(OP_MFHI, '0, '0, 5'd0);
      send_word(OP_DDIV, -64'sd7, 64'd2, 5'd0);
      send_word(OP_MFHI, '0, '0, 5'd0);
      send_word(OP_DMULT, '1, 64'h8000_0000_0000_0000, 5'd0);
      send_word(OP_MFHI, '0, '0, 5'd0);
      send_word(OP_MULTU, '1, '1, 5'd0);
      send_word(OP_MFLO, '0, '0, 5'd0);
      send_word(OP_SLT, 64'h8000_0000_0000_0000, 64'd1, 5'd0);
      send_word(OP_SYSCALL_FREE, '0, '0, 5'd0);

      // Hold the receiver off so the unit backs up.
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int k = 0; k < 20; k++)
            send_word(valid_ops[$urandom_range(40)], rand_operand(), rand_operand(),
                      5'($urandom()));
      join

      for (i = 0; i < 1950; i++) begin
         if (i == 1750) calm = 1'b1;
         if ($urandom_range(15) == 0) op = 6'($urandom());
         else op = valid_ops[$urandom_range(40)];
         // keep long multiply/divide words to a fraction of the run
         if (op inside {[OP_MULT:OP_DDIVU]} && $urandom_range(2) != 0)
            op = OP_MFHI + 6'($urandom_range(3));
         rs = rand_operand();
         rt = rand_operand();
         send_word(op, rs, rt, 5'($urandom()));
      end
      req_tvalid <= 1'b0;

      while (sb.rd_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0)
         $display("mips64_special_integer_unit verification clean");
      else
         $display("mips64_special_integer_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- mips64_special_integer_unit.f -----
sv/msiu_pkg.sv
sv/msiu_ctrl.sv
sv/msiu_dpath.sv
sv/mips64_special_integer_unit.sv
dv/tb_mips64_special_integer_unit.sv
